// ----- sv/can_tbq_pkg.sv -----
`timescale 1ns / 1ps

package can_tbq_pkg;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 4;
    localparam int IDENT_W = 11;
    localparam int LEN_W   = 4;
    localparam int MBOX_W  = 3;
    localparam int CHOSEN_W = 2;
    localparam int DEL_W   = 2;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 5;

    localparam logic [COUNT_W-1:0]  COUNT_MAX = 8'd255;
    localparam logic [CFG_W-1:0]    CFG_RESET = 5'd16;
    localparam logic [CHOSEN_W-1:0] MBOX_NONE = 2'd3;

    localparam logic [DEL_W-1:0] DEL_NONE    = 2'd0;
    localparam logic [DEL_W-1:0] DEL_INHIBIT = 2'd1;
    localparam logic [DEL_W-1:0] DEL_SYNC    = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_SETUP = 2'd0,
        MODE_SEND  = 2'd1,
        MODE_DONE  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_READ,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the request fields
        logic exec;     // run the per-mode operation
        logic scan;     // examine one buffer
        logic capture;  // take the identifier and length read data
        logic emit;     // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic exec_hand;  // send goes straight to a mailbox
        logic exec_scan;  // done or clear needs a buffer sweep
        logic scan_end;   // sweep index reached the active size
        logic scan_hand;  // sweep found the buffer to hand over
        logic out_free;   // output register can take a result
    } t_sts;

    function automatic logic [CHOSEN_W-1:0] lowest_empty(input logic [MBOX_W-1:0] mask);
        logic [CHOSEN_W-1:0] r;
        begin
            if (mask[0]) begin
                r = 2'd0;
            end else if (mask[1]) begin
                r = 2'd1;
            end else if (mask[2]) begin
                r = 2'd2;
            end else begin
                r = MBOX_NONE;
            end
            return r;
        end
    endfunction

endpackage

// ----- sv/can_transmit_buffer_queue_top.sv -----
`timescale 1ns / 1ps

// CAN transmit buffer queue: takes one request at a time (set up, send, transmit done,
// clear pending sync) and returns one result per request through a registered output.
// Set up and send pass the execute and emit states, and a send that hands the buffer over
// also passes a read state for the identifier/length read; transmit done and clear, while
// buffers are queued, sweep the buffer table one entry per cycle over the first
// min(buffers_in_use, TX_BUFFERS) entries, the done sweep stopping at a pending buffer.
// The next request can be accepted in the same cycle as the result appears. A result
// waits in the output register until taken; the next request is accepted meanwhile, and
// its result is held back until the register frees up. The user must write buffers_in_use
// through i_cfg_wr_en/i_cfg_wr_data while no request is open; the block does not check.

module can_transmit_buffer_queue_top #(
    parameter int TX_BUFFERS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [can_tbq_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [can_tbq_pkg::MODE_W-1:0]         i_mode,
    input  logic [can_tbq_pkg::INDEX_W-1:0]        i_buffer_index,
    input  logic [can_tbq_pkg::IDENT_W-1:0]        i_frame_ident,
    input  logic [can_tbq_pkg::LEN_W-1:0]          i_frame_length,
    input  logic                                   i_sync_mark,
    input  logic [can_tbq_pkg::MBOX_W-1:0]         i_mailbox_empty,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_transmit_now,
    output logic [can_tbq_pkg::INDEX_W-1:0]        o_sent_index,
    output logic [can_tbq_pkg::IDENT_W-1:0]        o_sent_ident,
    output logic [can_tbq_pkg::LEN_W-1:0]          o_sent_length,
    output logic [can_tbq_pkg::CHOSEN_W-1:0]       o_mailbox_chosen,
    output logic                                   o_overflow,
    output logic                                   o_overflow_reported,
    output logic [can_tbq_pkg::DEL_W-1:0]          o_deleted_code,
    output logic [can_tbq_pkg::COUNT_W-1:0]        o_queued_count
);
    import can_tbq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    can_tbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    can_tbq_dpath #(
        .TX_BUFFERS (TX_BUFFERS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_mode              (i_mode),
        .i_buffer_index      (i_buffer_index),
        .i_frame_ident       (i_frame_ident),
        .i_frame_length      (i_frame_length),
        .i_sync_mark         (i_sync_mark),
        .i_mailbox_empty     (i_mailbox_empty),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_transmit_now      (o_transmit_now),
        .o_sent_index        (o_sent_index),
        .o_sent_ident        (o_sent_ident),
        .o_sent_length       (o_sent_length),
        .o_mailbox_chosen    (o_mailbox_chosen),
        .o_overflow          (o_overflow),
        .o_overflow_reported (o_overflow_reported),
        .o_deleted_code      (o_deleted_code),
        .o_queued_count      (o_queued_count)
    );

    // One request in flight: ready drops right after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    // Commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.exec, w_cmd.scan, w_cmd.capture, w_cmd.emit}))
        else $error("controller issued overlapping commands");

    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result emitted into a full output register");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out_valid)
        else $error("emitted result not presented");

endmodule

// ----- sv/can_tbq_ctrl.sv -----
`timescale 1ns / 1ps

module can_tbq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  can_tbq_pkg::t_sts  i_sts,
    output can_tbq_pkg::t_cmd  o_cmd
);
    import can_tbq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.exec_hand) begin
                    n_state = S_READ;
                end else if (i_sts.exec_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_hand) begin
                    n_state = S_READ;
                end else if (i_sts.scan_end) begin
                    n_state = S_EMIT;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/can_tbq_dpath.sv -----
`timescale 1ns / 1ps

module can_tbq_dpath #(
    parameter int TX_BUFFERS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [can_tbq_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  logic [can_tbq_pkg::MODE_W-1:0]         i_mode,
    input  logic [can_tbq_pkg::INDEX_W-1:0]        i_buffer_index,
    input  logic [can_tbq_pkg::IDENT_W-1:0]        i_frame_ident,
    input  logic [can_tbq_pkg::LEN_W-1:0]          i_frame_length,
    input  logic                                   i_sync_mark,
    input  logic [can_tbq_pkg::MBOX_W-1:0]         i_mailbox_empty,
    input  can_tbq_pkg::t_cmd                      i_cmd,
    output can_tbq_pkg::t_sts                      o_sts,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_transmit_now,
    output logic [can_tbq_pkg::INDEX_W-1:0]        o_sent_index,
    output logic [can_tbq_pkg::IDENT_W-1:0]        o_sent_ident,
    output logic [can_tbq_pkg::LEN_W-1:0]          o_sent_length,
    output logic [can_tbq_pkg::CHOSEN_W-1:0]       o_mailbox_chosen,
    output logic                                   o_overflow,
    output logic                                   o_overflow_reported,
    output logic [can_tbq_pkg::DEL_W-1:0]          o_deleted_code,
    output logic [can_tbq_pkg::COUNT_W-1:0]        o_queued_count
);
    import can_tbq_pkg::*;

    localparam int IDX_W = (TX_BUFFERS > 1) ? $clog2(TX_BUFFERS) : 1;
    localparam int CNT_W = $clog2(TX_BUFFERS + 1);

    // Control state
    logic [TX_BUFFERS-1:0] r_pending, n_pending;
    logic [TX_BUFFERS-1:0] r_sync, n_sync;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic                  r_inhibit, n_inhibit;
    logic                  r_first, n_first;
    logic [CFG_W-1:0]      r_cfg, n_cfg;
    logic                  r_out_valid, n_out_valid;

    // Captured request
    t_mode                 r_mode, n_mode;
    logic [INDEX_W-1:0]    r_idx, n_idx;
    logic [IDENT_W-1:0]    r_ident, n_ident;
    logic [LEN_W-1:0]      r_length, n_length;
    logic                  r_sync_mark, n_sync_mark;
    logic [CHOSEN_W-1:0]   r_mbox, n_mbox;
    logic [CNT_W-1:0]      r_scan, n_scan;

    // Result under construction
    logic                  r_res_tx, n_res_tx;
    logic [INDEX_W-1:0]    r_res_index, n_res_index;
    logic [IDENT_W-1:0]    r_res_ident, n_res_ident;
    logic [LEN_W-1:0]      r_res_length, n_res_length;
    logic [CHOSEN_W-1:0]   r_res_mbox, n_res_mbox;
    logic                  r_res_ovf, n_res_ovf;
    logic                  r_res_rep, n_res_rep;
    logic [DEL_W-1:0]      r_res_code, n_res_code;

    // Output register
    logic                  r_out_tx, n_out_tx;
    logic [INDEX_W-1:0]    r_out_index, n_out_index;
    logic [IDENT_W-1:0]    r_out_ident, n_out_ident;
    logic [LEN_W-1:0]      r_out_length, n_out_length;
    logic [CHOSEN_W-1:0]   r_out_mbox, n_out_mbox;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_rep, n_out_rep;
    logic [DEL_W-1:0]      r_out_code, n_out_code;
    logic [COUNT_W-1:0]    r_out_count, n_out_count;

    // Identifier and length store
    logic [IDENT_W-1:0]    r_mem_ident [TX_BUFFERS];
    logic [LEN_W-1:0]      r_mem_length [TX_BUFFERS];
    logic [IDENT_W-1:0]    r_rd_ident;
    logic [LEN_W-1:0]      r_rd_length;

    logic [CNT_W-1:0]      w_size;
    logic                  w_in_range;
    logic [IDX_W-1:0]      w_addr;
    logic [IDX_W-1:0]      w_scan_addr;
    logic [IDX_W-1:0]      w_rd_addr;
    logic                  w_mem_we;
    logic                  w_mem_re;
    logic                  w_scan_end;
    logic [COUNT_W-1:0]    w_count_inc;
    logic [COUNT_W-1:0]    w_count_dec;

    assign w_size      = (int'(r_cfg) < TX_BUFFERS) ? CNT_W'(r_cfg) : CNT_W'(TX_BUFFERS);
    assign w_in_range  = int'(r_idx) < int'(w_size);
    assign w_addr      = IDX_W'(r_idx);
    assign w_scan_addr = r_scan[IDX_W-1:0];
    assign w_scan_end  = r_scan >= w_size;
    assign w_count_inc = (r_count != COUNT_MAX) ? r_count + 8'd1 : r_count;
    assign w_count_dec = (r_count != '0) ? r_count - 8'd1 : r_count;

    assign w_mem_we  = i_cmd.exec && (r_mode == MODE_SETUP) && w_in_range;
    assign w_mem_re  = i_cmd.exec || i_cmd.scan;
    assign w_rd_addr = i_cmd.scan ? w_scan_addr : w_addr;

    assign o_sts.exec_hand = (r_mode == MODE_SEND) && w_in_range
                             && (r_mbox != MBOX_NONE) && (r_count == '0);
    assign o_sts.exec_scan = ((r_mode == MODE_DONE) || (r_mode == MODE_CLEAR))
                             && (r_count != '0);
    assign o_sts.scan_end  = w_scan_end;
    assign o_sts.scan_hand = (r_mode == MODE_DONE) && !w_scan_end && r_pending[w_scan_addr];
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_pending    = r_pending;
        n_sync       = r_sync;
        n_count      = r_count;
        n_inhibit    = r_inhibit;
        n_first      = r_first;
        n_cfg        = r_cfg;
        n_out_valid  = r_out_valid;
        n_mode       = r_mode;
        n_idx        = r_idx;
        n_ident      = r_ident;
        n_length     = r_length;
        n_sync_mark  = r_sync_mark;
        n_mbox       = r_mbox;
        n_scan       = r_scan;
        n_res_tx     = r_res_tx;
        n_res_index  = r_res_index;
        n_res_ident  = r_res_ident;
        n_res_length = r_res_length;
        n_res_mbox   = r_res_mbox;
        n_res_ovf    = r_res_ovf;
        n_res_rep    = r_res_rep;
        n_res_code   = r_res_code;
        n_out_tx     = r_out_tx;
        n_out_index  = r_out_index;
        n_out_ident  = r_out_ident;
        n_out_length = r_out_length;
        n_out_mbox   = r_out_mbox;
        n_out_ovf    = r_out_ovf;
        n_out_rep    = r_out_rep;
        n_out_code   = r_out_code;
        n_out_count  = r_out_count;

        if (i_cfg_wr_en) n_cfg = i_cfg_wr_data;

        if (i_cmd.load) begin
            n_mode       = t_mode'(i_mode);
            n_idx        = i_buffer_index;
            n_ident      = i_frame_ident;
            n_length     = i_frame_length;
            n_sync_mark  = i_sync_mark;
            n_mbox       = lowest_empty(i_mailbox_empty);
            n_scan       = '0;
            n_res_tx     = 1'b0;
            n_res_index  = '0;
            n_res_ident  = '0;
            n_res_length = '0;
            n_res_mbox   = MBOX_NONE;
            n_res_ovf    = 1'b0;
            n_res_rep    = 1'b0;
            n_res_code   = DEL_NONE;
        end

        if (i_cmd.exec) begin
            case (r_mode)
                MODE_SETUP: begin
                    if (w_in_range) begin
                        n_pending[w_addr] = 1'b0;
                        n_sync[w_addr]    = r_sync_mark;
                    end
                end
                MODE_SEND: begin
                    if (w_in_range) begin
                        n_res_mbox = r_mbox;
                        if (r_pending[w_addr]) begin
                            n_res_ovf = 1'b1;
                            n_res_rep = !r_first;
                        end
                        if (o_sts.exec_hand) begin
                            n_res_tx    = 1'b1;
                            n_res_index = r_idx;
                            n_inhibit   = r_sync[w_addr];
                        end else begin
                            n_pending[w_addr] = 1'b1;
                            n_count           = w_count_inc;
                        end
                    end
                end
                MODE_DONE: begin
                    n_first    = 1'b0;
                    n_inhibit  = 1'b0;
                    n_res_mbox = r_mbox;
                end
                MODE_CLEAR: begin
                    if (r_inhibit) begin
                        n_inhibit  = 1'b0;
                        n_res_code = DEL_INHIBIT;
                    end
                end
                default: begin
                    n_res_code = DEL_NONE;
                end
            endcase
        end

        if (i_cmd.scan) begin
            if (w_scan_end) begin
                // nothing pending in range: drop the stale count
                if (r_mode == MODE_DONE) n_count = '0;
            end else begin
                if (o_sts.scan_hand) begin
                    n_pending[w_scan_addr] = 1'b0;
                    n_count                = w_count_dec;
                    n_res_tx               = 1'b1;
                    n_res_index            = INDEX_W'(r_scan);
                    n_inhibit              = r_sync[w_scan_addr];
                end
                if ((r_mode == MODE_CLEAR) && r_pending[w_scan_addr] && r_sync[w_scan_addr]) begin
                    n_pending[w_scan_addr] = 1'b0;
                    n_count                = w_count_dec;
                    n_res_code             = DEL_SYNC;
                end
                n_scan = r_scan + CNT_W'(1);
            end
        end

        if (i_cmd.capture) begin
            n_res_ident  = r_rd_ident;
            n_res_length = r_rd_length;
        end

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        if (i_cmd.emit) begin
            n_out_valid  = 1'b1;
            n_out_tx     = r_res_tx;
            n_out_index  = r_res_index;
            n_out_ident  = r_res_ident;
            n_out_length = r_res_length;
            n_out_mbox   = r_res_mbox;
            n_out_ovf    = r_res_ovf;
            n_out_rep    = r_res_rep;
            n_out_code   = r_res_code;
            n_out_count  = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_sync      <= '0;
            r_count     <= '0;
            r_inhibit   <= 1'b0;
            r_first     <= 1'b1;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_sync      <= n_sync;
            r_count     <= n_count;
            r_inhibit   <= n_inhibit;
            r_first     <= n_first;
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_idx        <= n_idx;
        r_ident      <= n_ident;
        r_length     <= n_length;
        r_sync_mark  <= n_sync_mark;
        r_mbox       <= n_mbox;
        r_scan       <= n_scan;
        r_res_tx     <= n_res_tx;
        r_res_index  <= n_res_index;
        r_res_ident  <= n_res_ident;
        r_res_length <= n_res_length;
        r_res_mbox   <= n_res_mbox;
        r_res_ovf    <= n_res_ovf;
        r_res_rep    <= n_res_rep;
        r_res_code   <= n_res_code;
        r_out_tx     <= n_out_tx;
        r_out_index  <= n_out_index;
        r_out_ident  <= n_out_ident;
        r_out_length <= n_out_length;
        r_out_mbox   <= n_out_mbox;
        r_out_ovf    <= n_out_ovf;
        r_out_rep    <= n_out_rep;
        r_out_code   <= n_out_code;
        r_out_count  <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem_ident[w_addr]  <= r_ident;
            r_mem_length[w_addr] <= r_length;
        end
        if (w_mem_re) begin
            r_rd_ident  <= r_mem_ident[w_rd_addr];
            r_rd_length <= r_mem_length[w_rd_addr];
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_transmit_now      = r_out_tx;
    assign o_sent_index        = r_out_index;
    assign o_sent_ident        = r_out_ident;
    assign o_sent_length       = r_out_length;
    assign o_mailbox_chosen    = r_out_mbox;
    assign o_overflow          = r_out_ovf;
    assign o_overflow_reported = r_out_rep;
    assign o_deleted_code      = r_out_code;
    assign o_queued_count      = r_out_count;

endmodule
